// ----- design/alc_pkg.sv -----
// package: shared constants, command and status types for the auto levels block
`timescale 1ns / 1ps
package alc_pkg;

  localparam int unsigned MAX_PIXELS = 4194304;
  localparam int unsigned CNT_W      = 23;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned PROD_W     = 38;
  localparam int unsigned LIM_W      = 40;
  localparam int unsigned TOL_W      = 15;
  localparam int unsigned BLACK_MAX  = 85;
  localparam int unsigned WHITE_MIN  = 170;
  localparam int unsigned LIM_ROUND  = 12800;

  // result status codes
  localparam logic [1:0] ST_MAPPED   = 2'd0;
  localparam logic [1:0] ST_POINTS   = 2'd1;
  localparam logic [1:0] ST_NO_PIX   = 2'd2;
  localparam logic [1:0] ST_NO_CHG   = 2'd3;

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_TOL  = 1'b1;

  // input kinds
  localparam logic OP_GATHER = 1'b0;
  localparam logic OP_MAP    = 1'b1;

  typedef struct packed {
    logic       take;
    logic       hist_upd;
    logic       map_out;
    logic       mul;
    logic       lim;
    logic       scan_init;
    logic       scan_acc;
    logic       scan_step;
    logic       store_pt;
    logic       is_black;
    logic [1:0] ch;
    logic       decide;
    logic       build_step;
    logic       report;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_more;
    logic build_end;
    logic mode;
    logic out_valid;
  } sts_t;

endpackage

// ----- design/auto_levels_contrast_stretch.sv -----
// Map item: the table read is registered at the transfer and the result register is
// loaded from it in S_MAP; every item holds off the input until done, one item at a time.
// Last gather item: each scanned bin passes the read, accumulate and compare states
// (up to 86 bins per scan, two scans per channel, three channels in levels mode),
// then the one-step-a-cycle rounding divider builds each table; the result follows it.
// Reset: synchronous; after reset a build pass clears the histograms and loads identity
// tables, during which no item is accepted (configuration writes are taken).
`timescale 1ns / 1ps
module auto_levels_contrast_stretch (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // red, green, blue, alpha
  input  logic        s_tuser,   // operation
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // out_red, out_green, out_blue, out_alpha, black_red,
                                 // black_green, black_blue, white_red, white_green,
                                 // white_blue, zero pad
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);
  import alc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  alc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  alc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- design/alc_ctrl.sv -----
// controller: sequences gather, map, limit, scan, table build and report
`timescale 1ns / 1ps
module alc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tuser,
  input  logic          s_tlast,
  input  logic          m_tready,
  output logic          s_tready,
  output alc_pkg::cmd_t cmd,
  input  alc_pkg::sts_t sts
);
  import alc_pkg::*;

  typedef enum logic [3:0] {
    S_BUILD, S_IDLE, S_GATHER, S_MAP, S_MUL, S_LIM,
    S_SINIT, S_SRD, S_SACC, S_SCMP, S_DECIDE, S_REPORT
  } state_t;

  state_t     state;
  logic [1:0] ch;
  logic       is_black;
  logic       pend;
  logic       take;

  assign s_tready = (state == S_IDLE) && (!sts.out_valid || m_tready);
  assign take     = s_tvalid && s_tready;

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.take       = take;
    cmd.ch         = ch;
    cmd.is_black   = is_black;
    cmd.hist_upd   = (state == S_GATHER);
    cmd.map_out    = (state == S_MAP);
    cmd.mul        = (state == S_MUL);
    cmd.lim        = (state == S_LIM);
    cmd.scan_init  = (state == S_SINIT);
    cmd.scan_acc   = (state == S_SACC);
    cmd.scan_step  = (state == S_SCMP) && sts.scan_more;
    cmd.store_pt   = (state == S_SCMP) && !sts.scan_more;
    cmd.decide     = (state == S_DECIDE);
    cmd.build_step = (state == S_BUILD);
    cmd.report     = (state == S_REPORT);
  end

  // state and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_BUILD;
      ch       <= 2'd0;
      is_black <= 1'b0;
      pend     <= 1'b0;
    end else begin
      case (state)
        S_BUILD: begin
          if (sts.build_end) begin
            if (ch == 2'd2) begin
              ch    <= 2'd0;
              state <= pend ? S_REPORT : S_IDLE;
            end else begin
              ch <= ch + 2'd1;
            end
          end
        end
        S_IDLE: begin
          if (take) begin
            if (s_tuser == OP_MAP) begin
              state <= S_MAP;
            end else begin
              pend  <= s_tlast;
              state <= S_GATHER;
            end
          end
        end
        S_GATHER: state <= pend ? S_MUL : S_IDLE;
        S_MAP:    state <= S_IDLE;
        S_MUL:    state <= S_LIM;
        S_LIM: begin
          ch       <= 2'd0;
          is_black <= 1'b0;
          state    <= sts.count_zero ? S_DECIDE : S_SINIT;
        end
        S_SINIT: state <= S_SRD;
        S_SRD:   state <= S_SACC;
        S_SACC:  state <= S_SCMP;
        S_SCMP: begin
          if (sts.scan_more) begin
            state <= S_SRD;
          end else if (!is_black) begin
            is_black <= 1'b1;
            state    <= S_SINIT;
          end else begin
            is_black <= 1'b0;
            if (sts.mode && ch != 2'd2) begin
              ch    <= ch + 2'd1;
              state <= S_SINIT;
            end else begin
              ch    <= 2'd0;
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: state <= S_BUILD;
        S_REPORT: begin
          pend  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/alc_datapath.sv -----
// datapath: histograms, map tables, limit, scan, table builder and output register
`timescale 1ns / 1ps
module alc_datapath (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   s_tdata,
  input  logic          cfg_valid,
  input  logic          cfg_index,
  input  logic [14:0]   cfg_data,
  input  logic          m_tready,
  output logic [79:0]   m_tdata,
  output logic [1:0]    m_tuser,
  output logic          m_tvalid,
  input  alc_pkg::cmd_t cmd,
  output alc_pkg::sts_t sts
);
  import alc_pkg::*;

  logic [CNT_W-1:0]  hist_r [256];
  logic [CNT_W-1:0]  hist_g [256];
  logic [CNT_W-1:0]  hist_b [256];
  logic [7:0]        tbl_r [256];
  logic [7:0]        tbl_g [256];
  logic [7:0]        tbl_b [256];

  logic              mode;
  logic [TOL_W-1:0]  tol;
  logic [7:0]        pr, pg, pb, pa;
  logic [CNT_W-1:0]  hq_r, hq_g, hq_b;
  logic [7:0]        tq_r, tq_g, tq_b;
  logic [CNT_W-1:0]  count;
  logic [PROD_W-1:0] prod;
  logic [LIM_W-1:0]  lim_x;
  logic [7:0]        pos;
  logic [SUM_W-1:0]  sum;
  logic [6:0]        black [3];
  logic [7:0]        white [3];
  logic              ident;
  logic [1:0]        status;
  logic [7:0]        bi;
  logic [8:0]        rem;
  logic [7:0]        q;

  logic [7:0]        ra_r, ra_g, ra_b;
  logic              counted;
  logic [SUM_W-1:0]  bin;
  logic [SUM_W:0]    s1;
  logic [LIM_W-1:0]  scaled;
  logic              edge_ok;
  logic [7:0]        cb, cw, span;
  logic              wr_en;
  logic [7:0]        wr_val;
  logic              nochg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      tol  <= TOL_W'(128);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MODE) mode <= cfg_data[0];
      else                       tol  <= cfg_data;
    end
  end

  // read addresses: pixel on a transfer, scan position otherwise
  assign ra_r = cmd.take ? s_tdata[7:0]   : pos;
  assign ra_g = cmd.take ? s_tdata[15:8]  : pos;
  assign ra_b = cmd.take ? s_tdata[23:16] : pos;

  assign counted = (pa != 8'd0) && (count < CNT_W'(MAX_PIXELS));

  // histogram memories: bump on gather, clear during table build
  always_ff @(posedge clk) begin
    hq_r <= hist_r[ra_r];
    hq_g <= hist_g[ra_g];
    hq_b <= hist_b[ra_b];
    if (cmd.hist_upd && counted) begin
      hist_r[pr] <= hq_r + CNT_W'(1);
      hist_g[pg] <= hq_g + CNT_W'(1);
      hist_b[pb] <= hq_b + CNT_W'(1);
    end else if (cmd.build_step) begin
      hist_r[bi] <= '0;
      hist_g[bi] <= '0;
      hist_b[bi] <= '0;
    end
  end

  // map table memories
  always_ff @(posedge clk) begin
    tq_r <= tbl_r[s_tdata[7:0]];
    tq_g <= tbl_g[s_tdata[15:8]];
    tq_b <= tbl_b[s_tdata[23:16]];
    if (cmd.build_step && wr_en) begin
      if (cmd.ch == 2'd0) tbl_r[bi] <= wr_val;
      if (cmd.ch == 2'd1) tbl_g[bi] <= wr_val;
      if (cmd.ch == 2'd2) tbl_b[bi] <= wr_val;
    end
  end

  // pixel latch and opaque count
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pr <= s_tdata[7:0];
      pg <= s_tdata[15:8];
      pb <= s_tdata[23:16];
      pa <= s_tdata[31:24];
    end
    if (rst || cmd.report) count <= '0;
    else if (cmd.hist_upd && counted) count <= count + CNT_W'(1);
  end

  // clip limit, kept scaled: sum < limit iff 25600*(sum+1) <= k*n*t + 12800
  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= PROD_W'(count) * PROD_W'(tol);
    if (cmd.lim) begin
      if (mode) lim_x <= LIM_W'(prod) + LIM_W'(LIM_ROUND);
      else      lim_x <= LIM_W'(prod) + (LIM_W'(prod) << 1) + LIM_W'(LIM_ROUND);
    end
  end

  // scan bin: own channel in levels mode, sum of channels in contrast mode
  always_comb begin
    if (mode) begin
      case (cmd.ch)
        2'd0:    bin = SUM_W'(hq_r);
        2'd1:    bin = SUM_W'(hq_g);
        default: bin = SUM_W'(hq_b);
      endcase
    end else begin
      bin = SUM_W'(hq_r) + SUM_W'(hq_g) + SUM_W'(hq_b);
    end
  end

  assign s1      = {1'b0, sum} + (SUM_W+1)'(1);
  assign scaled  = (LIM_W'(s1) << 14) + (LIM_W'(s1) << 13) + (LIM_W'(s1) << 10);
  assign edge_ok = cmd.is_black ? (pos < 8'(BLACK_MAX)) : (pos > 8'(WHITE_MIN));

  // scan position and running sum
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      pos <= cmd.is_black ? 8'd0 : 8'd255;
      sum <= '0;
    end else if (cmd.scan_acc) begin
      sum <= sum + bin;
    end else if (cmd.scan_step) begin
      pos <= cmd.is_black ? pos + 8'd1 : pos - 8'd1;
    end
  end

  assign nochg = (black[0] == 7'd0) && (black[1] == 7'd0) && (black[2] == 7'd0) &&
                 (white[0] == 8'd255) && (white[1] == 8'd255) && (white[2] == 8'd255);

  // points, status and identity flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        black[c] <= 7'd0;
        white[c] <= 8'd255;
      end
      ident  <= 1'b1;
      status <= ST_NO_PIX;
    end else if (cmd.store_pt) begin
      for (int c = 0; c < 3; c++) begin
        if (!mode || cmd.ch == 2'(c)) begin
          if (cmd.is_black) black[c] <= pos[6:0];
          else              white[c] <= pos;
        end
      end
    end else if (cmd.decide) begin
      if (count == '0) begin
        for (int c = 0; c < 3; c++) begin
          black[c] <= 7'd0;
          white[c] <= 8'd255;
        end
        ident  <= 1'b1;
        status <= ST_NO_PIX;
      end else if (nochg) begin
        ident  <= 1'b1;
        status <= ST_NO_CHG;
      end else begin
        ident  <= 1'b0;
        status <= ST_POINTS;
      end
    end
  end

  // table builder: rounding divide by stepping quotient and remainder
  always_comb begin
    case (cmd.ch)
      2'd0:    begin cb = {1'b0, black[0]}; cw = white[0]; end
      2'd1:    begin cb = {1'b0, black[1]}; cw = white[1]; end
      default: begin cb = {1'b0, black[2]}; cw = white[2]; end
    endcase
    span   = cw - cb;
    wr_en  = 1'b1;
    wr_val = q;
    if (ident)              wr_val = bi;
    else if (bi <= cb)      wr_val = 8'd0;
    else if (bi >= cw)      wr_val = 8'd255;
    else if (rem >= {1'b0, span}) wr_en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bi <= 8'd0;
    end else if (cmd.build_step) begin
      if (wr_en) bi <= bi + 8'd1;
      if (bi <= cb) begin
        rem <= {2'b0, span[7:1]} + 9'd255;
        q   <= 8'd0;
      end else if (bi < cw) begin
        if (rem >= {1'b0, span}) begin
          rem <= rem - {1'b0, span};
          q   <= q + 8'd1;
        end else begin
          rem <= rem + 9'd255;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.map_out || cmd.report) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.map_out) begin
      m_tuser       <= ST_MAPPED;
      m_tdata[31:0] <= (pa != 8'd0) ? {pa, tq_b, tq_g, tq_r} : {pa, pb, pg, pr};
    end else if (cmd.report) begin
      m_tuser       <= status;
      m_tdata[31:0] <= '0;
    end
    if (cmd.map_out || cmd.report) begin
      m_tdata[79:32] <= {3'b0, white[2], white[1], white[0], black[2], black[1], black[0]};
    end
  end

  assign sts.count_zero = (count == '0);
  assign sts.scan_more  = (scaled <= lim_x) && edge_ok;
  assign sts.build_end  = cmd.build_step && wr_en && (bi == 8'd255);
  assign sts.mode       = mode;
  assign sts.out_valid  = m_tvalid;

endmodule

// ----- design/alc_checker.sv -----
// checker: port-level properties of the auto levels block, bound to the top level
`timescale 1ns / 1ps
module alc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import alc_pkg::*;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // input is taken only when the output register can take a result
  a_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || m_tready)
    else $error("input ready while output blocked");

  // black points stay in range, white points stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[38:32] <= 7'd85 && m_tdata[45:39] <= 7'd85 &&
                 m_tdata[52:46] <= 7'd85 && m_tdata[60:53] >= 8'd170 &&
                 m_tdata[68:61] >= 8'd170 && m_tdata[76:69] >= 8'd170)
    else $error("point out of range");

  // identity summaries carry default points
  a_ident: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_NO_PIX || m_tuser == ST_NO_CHG) |->
      m_tdata[52:32] == 21'd0 && m_tdata[76:53] == 24'hFFFFFF)
    else $error("identity summary with moved points");

endmodule

bind auto_levels_contrast_stretch alc_checker u_alc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
